>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OQKR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define OQKR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/oqkr_pkg.sv
// Package: types and constants of the ordered queue with key removal.
`default_nettype none
package oqkr_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int KEY_BITS_DEF = 16;
   localparam int PLATE_W      = 16;
   localparam int OUT_W        = 5;

   localparam logic KIND_ARRIVE = 1'b0;
   localparam logic KIND_DEPART = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPEND,
      ST_SCAN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;    // capture key, clear walk counters
      logic append;  // write key at tail unless full
      logic scan;    // advance compaction walk
      logic commit;  // take compacted length as new count
   } cmd_type;

   typedef struct packed {
      logic scan_done;
   } status_type;

endpackage
`default_nettype wire

>>> hw/rtl/oqkr_ctrl.sv
// Controller state machine of the ordered queue.
`default_nettype none
module oqkr_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   input  wire                 req_kind,
   input  oqkr_pkg::status_type status,
   output oqkr_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_valid
);
   import oqkr_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_kind == KIND_DEPART) ? ST_SCAN : ST_APPEND;
            end
         end
         ST_APPEND: state_in = ST_RESP;
         ST_SCAN: begin
            if (status.scan_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         ST_APPEND: cmd.append = 1'b1;
         ST_SCAN: begin
            cmd.scan   = 1'b1;
            cmd.commit = status.scan_done;
         end
         ST_RESP: rsp_valid = 1'b1;
         default: busy = 1'b1;
      endcase
   end

endmodule
`default_nettype wire

>>> hw/rtl/oqkr_datapath.sv
// Datapath: key memory, compaction walk and result registers.
`default_nettype none
module oqkr_datapath #(
   parameter int CAPACITY = oqkr_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = oqkr_pkg::KEY_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  oqkr_pkg::cmd_type                cmd,
   input  wire  [oqkr_pkg::PLATE_W-1:0]     req_plate,
   output oqkr_pkg::status_type             status,
   output logic [oqkr_pkg::OUT_W-1:0]       rsp_occupancy,
   output logic [oqkr_pkg::OUT_W-1:0]       rsp_removed_count,
   output logic                             rsp_rejected
);
   import oqkr_pkg::*;

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int ADDR_W = $clog2(CAPACITY);

   logic [KEY_BITS-1:0] mem [CAPACITY];

   logic [KEY_BITS-1:0] key_ff;
   logic [KEY_BITS-1:0] rd_data_ff;
   logic                rd_valid_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    src_ff;
   logic [CNT_W-1:0]    dst_ff;
   logic [CNT_W-1:0]    removed_ff;
   logic                rejected_ff;

   logic [KEY_BITS+PLATE_W-1:0] key_wide;
   logic [CNT_W+OUT_W-1:0]      occ_wide;
   logic [CNT_W+OUT_W-1:0]      rem_wide;
   logic                        full;
   logic                        issue;
   logic                        match;
   logic                        do_append;

   // plate is masked or zero-extended to the key width
   assign key_wide  = {{KEY_BITS{1'b0}}, req_plate};
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign do_append = cmd.append && !full;
   assign issue     = cmd.scan && (src_ff != count_ff);
   assign match     = (rd_data_ff == key_ff);

   assign status.scan_done = (src_ff == count_ff) && !rd_valid_ff;

   // read stage at src, compare/write stage at dst in the cycle after; dst < src+1
   always_ff @(posedge clock) begin
      if (do_append) begin
         mem[count_ff[ADDR_W-1:0]] <= key_ff;
      end else if (rd_valid_ff && !match) begin
         mem[dst_ff[ADDR_W-1:0]] <= rd_data_ff;
      end
      if (issue) begin
         rd_data_ff <= mem[src_ff[ADDR_W-1:0]];
      end
      if (cmd.load) begin
         key_ff <= key_wide[KEY_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         src_ff      <= '0;
         dst_ff      <= '0;
         removed_ff  <= '0;
         rejected_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= issue;
         if (cmd.load) begin
            src_ff      <= '0;
            dst_ff      <= '0;
            removed_ff  <= '0;
            rejected_ff <= 1'b0;
         end else begin
            if (issue) begin
               src_ff <= src_ff + CNT_W'(1);
            end
            if (rd_valid_ff) begin
               if (match) begin
                  removed_ff <= removed_ff + CNT_W'(1);
               end else begin
                  dst_ff <= dst_ff + CNT_W'(1);
               end
            end
            if (cmd.append && full) begin
               rejected_ff <= 1'b1;
            end
         end
         if (do_append) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.commit) begin
            count_ff <= dst_ff;
         end
      end
   end

   assign occ_wide          = {{OUT_W{1'b0}}, count_ff};
   assign rem_wide          = {{OUT_W{1'b0}}, removed_ff};
   assign rsp_occupancy     = occ_wide[OUT_W-1:0];
   assign rsp_removed_count = rem_wide[OUT_W-1:0];
   assign rsp_rejected      = rejected_ff;

endmodule
`default_nettype wire

>>> hw/rtl/ordered_queue_with_key_removal.sv
// Ordered queue of keys with append at the tail and removal of every matching key.
//
// Usage: drive req_kind (0 arrive, 1 depart) and req_plate with start high;
// the item is taken at the edge where start is high and busy is low.
// Arrive appends the key at the tail; on a full queue the key is dropped and
// rsp_rejected is set. Depart removes every entry equal to the key and keeps
// the order of the rest.
// Each item gives one result: rsp_valid is high for exactly one cycle with
// rsp_occupancy, rsp_removed_count and rsp_rejected; the receiver cannot stall.
// A depart walks the queue, reading one entry a cycle through the single read port
// and writing survivors back in the cycle after their read. busy stays high from
// accept through the result cycle, so one item is at work at a time; the next
// item can be taken the cycle after the result.
// Reset empties the queue (count to zero); memory contents are not cleared.
`default_nettype none
module ordered_queue_with_key_removal #(
   parameter int CAPACITY = oqkr_pkg::CAPACITY_DEF,
   parameter int KEY_BITS = oqkr_pkg::KEY_BITS_DEF
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   output logic                          busy,
   input  wire                           req_kind,
   input  wire  [oqkr_pkg::PLATE_W-1:0]  req_plate,
   output logic                          rsp_valid,
   output logic [oqkr_pkg::OUT_W-1:0]    rsp_occupancy,
   output logic [oqkr_pkg::OUT_W-1:0]    rsp_removed_count,
   output logic                          rsp_rejected
);
   import oqkr_pkg::*;

   cmd_type    cmd;
   status_type status;

   oqkr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_kind  (req_kind),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   oqkr_datapath #(
      .CAPACITY (CAPACITY),
      .KEY_BITS (KEY_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_plate         (req_plate),
      .status            (status),
      .rsp_occupancy     (rsp_occupancy),
      .rsp_removed_count (rsp_removed_count),
      .rsp_rejected      (rsp_rejected)
   );

endmodule
`default_nettype wire

>>> hw/rtl/oqkr_checker.sv
// Port-level checker for the ordered queue, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module oqkr_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          start,
   input wire                          busy,
   input wire                          req_kind,
   input wire                          rsp_valid,
   input wire [oqkr_pkg::OUT_W-1:0]    rsp_removed_count,
   input wire                          rsp_rejected
);
   import oqkr_pkg::*;

   `OQKR_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy,
                     "busy low after accept")
   `OQKR_ASSERT_NEXT(a_resp_idle, clock, reset, rsp_valid, !busy && !rsp_valid,
                     "not idle after result")
   `OQKR_ASSERT_IMPL(a_rej_none, clock, reset, rsp_valid && rsp_rejected,
                     rsp_removed_count == '0, "rejected with removals")
   `OQKR_ASSERT_NEXT(a_arrive_lat, clock, reset,
                     start && !busy && (req_kind == KIND_ARRIVE),
                     ##1 rsp_valid, "arrive result late")

endmodule

bind ordered_queue_with_key_removal oqkr_checker u_oqkr_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_kind          (req_kind),
   .rsp_valid         (rsp_valid),
   .rsp_removed_count (rsp_removed_count),
   .rsp_rejected      (rsp_rejected)
);
`default_nettype wire

>>> tb/ordered_queue_with_key_removal_tb.sv
// Testbench for the ordered key queue: random arrive/depart traffic checked against a local model.
`default_nettype none
module ordered_queue_with_key_removal_tb;
   import oqkr_pkg::*;

   localparam int SLOTS       = CAPACITY_DEF;
   localparam int STALL_LIMIT = 1000;
   localparam int DRAIN_WAIT  = SLOTS + 20;
   localparam int RANDOM_ITEMS = 1500;

   typedef struct packed {
      logic               kind;
      logic [PLATE_W-1:0] plate;
   } ticket_type;

   typedef struct packed {
      logic [OUT_W-1:0] occupancy;
      logic [OUT_W-1:0] removed_count;
      logic             rejected;
   } lot_status_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               req_kind = KIND_ARRIVE;
   logic [PLATE_W-1:0] req_plate = '0;
   wire                busy;
   wire                rsp_valid;
   wire  [OUT_W-1:0]   rsp_occupancy;
   wire  [OUT_W-1:0]   rsp_removed_count;
   wire                rsp_rejected;

   ticket_type         tickets_pending[$];
   lot_status_type     due_status[$];
   logic [PLATE_W-1:0] parked[$];

   int mismatches   = 0;
   int arrivals     = 0;
   int departures   = 0;
   int turned_away  = 0;
   int keys_removed = 0;
   int gap_left     = 0;
   int idle_cycles  = 0;
   bit gap_burst    = 1'b0;

   ordered_queue_with_key_removal DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_plate        (req_plate),
      .rsp_valid        (rsp_valid),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_removed_count(rsp_removed_count),
      .rsp_rejected     (rsp_rejected)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatches++;
   endtask

   // Applies one ticket to the local copy of the lot and queues the status it must give.
   function automatic void park_or_leave(input ticket_type t);
      lot_status_type     st;
      logic [PLATE_W-1:0] kept[$];
      int                 gone;
      st = '0;
      gone = 0;
      if (t.kind == KIND_ARRIVE) begin
         arrivals++;
         if (parked.size() >= SLOTS) begin
            st.rejected = 1'b1;
            turned_away++;
         end else begin
            parked.push_back(t.plate);
         end
      end else begin
         departures++;
         foreach (parked[i]) begin
            if (parked[i] == t.plate) gone++;
            else kept.push_back(parked[i]);
         end
         parked = kept;
         keys_removed += gone;
      end
      st.occupancy     = OUT_W'(parked.size());
      st.removed_count = OUT_W'(gone);
      due_status.push_back(st);
   endfunction

   function automatic int draw_gap();
      if ($urandom_range(0, 31) == 0) gap_burst = ~gap_burst;
      return gap_burst ? 0 : int'($urandom_range(0, 13));
   endfunction

   // Driver: an item moves at an edge where start is high and busy is low.
   always @(posedge clock) begin
      ticket_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) park_or_leave('{kind: req_kind, plate: req_plate});
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (tickets_pending.size() > 0) begin
               nxt = tickets_pending.pop_front();
               start     <= 1'b1;
               req_kind  <= nxt.kind;
               req_plate <= nxt.plate;
               gap_left  = draw_gap();
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: results cannot be stalled, so each strobe is checked as it comes.
   always @(posedge clock) begin
      lot_status_type want;
      if (!reset && rsp_valid) begin
         if (due_status.size() == 0) begin
            report_mismatch("result with no item outstanding");
         end else begin
            want = due_status.pop_front();
            if (rsp_occupancy !== want.occupancy)
               report_mismatch($sformatf("occupancy %0d, expected %0d",
                                         rsp_occupancy, want.occupancy));
            if (rsp_removed_count !== want.removed_count)
               report_mismatch($sformatf("removed_count %0d, expected %0d",
                                         rsp_removed_count, want.removed_count));
            if (rsp_rejected !== want.rejected)
               report_mismatch($sformatf("rejected %0b, expected %0b",
                                         rsp_rejected, want.rejected));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Timeout: no progress for %0d cycles", STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end
   end

   function automatic void add_ticket(input logic kind, input logic [PLATE_W-1:0] plate);
      tickets_pending.push_back('{kind: kind, plate: plate});
   endfunction

   initial begin
      logic [PLATE_W-1:0] fill_keys[16];
      logic [PLATE_W-1:0] pool[5];
      int                 arrive_pct;
      fill_keys = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'hFFFF, 16'h0001,
                    16'h8000, 16'hFFFF, 16'h1234, 16'h0000, 16'h7FFE, 16'hFFFF,
                    16'h00FF, 16'hFF00, 16'h0000, 16'hC3C3};

      // Directed: empty depart, fill to capacity, arrivals on a full lot,
      // depart with several matches, with no match, then two more matching departs.
      add_ticket(KIND_DEPART, 16'h1234);
      foreach (fill_keys[i]) add_ticket(KIND_ARRIVE, fill_keys[i]);
      add_ticket(KIND_ARRIVE, 16'hBEEF);
      add_ticket(KIND_ARRIVE, 16'hFFFF);
      add_ticket(KIND_DEPART, 16'hFFFF);
      add_ticket(KIND_DEPART, 16'h7777);
      add_ticket(KIND_DEPART, 16'h0000);
      add_ticket(KIND_DEPART, 16'h0001);

      // Random: phases with a small key pool so departs hit, and a bias that
      // fills the lot to the top, drains it, or keeps it near balance.
      arrive_pct = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 80 == 0) begin
            foreach (pool[i]) pool[i] = PLATE_W'($urandom);
            case ($urandom_range(0, 2))
               0: arrive_pct = 30;
               1: arrive_pct = 55;
               default: arrive_pct = 85;
            endcase
         end
         add_ticket(($urandom_range(0, 99) < arrive_pct) ? KIND_ARRIVE : KIND_DEPART,
                    ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 4)]
                                                 : PLATE_W'($urandom));
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (tickets_pending.size() != 0 || start || due_status.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Ran %0d arrivals (%0d turned away at full) and %0d departures",
               arrivals, turned_away, departures);
      $display("Departures removed %0d keys in total", keys_removed);
      if (mismatches == 0 && due_status.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d results never seen", mismatches, due_status.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
+incdir+hw/rtl
hw/rtl/oqkr_pkg.sv
hw/rtl/oqkr_ctrl.sv
hw/rtl/oqkr_datapath.sv
hw/rtl/ordered_queue_with_key_removal.sv
hw/rtl/oqkr_checker.sv
tb/ordered_queue_with_key_removal_tb.sv
